// ===== hdl/multilevel_queue_task_scheduler_assert.svh =====
// Assertion macros for the scheduler checker.
`ifndef MULTILEVEL_QUEUE_TASK_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_QUEUE_TASK_SCHEDULER_ASSERT_SVH
// Implication checked every clock, off during reset.
`define MQS_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define MQS_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== hdl/mqs_pkg.sv =====
package mqs_pkg;
  localparam int MaxTasks  = 64;
  localparam int NumQueues = 10;
  localparam int IdleTask  = 0;
  localparam int TidW      = $clog2(MaxTasks);
  localparam int ClsW      = 4;
  localparam int KeyW      = 33;
  localparam int ScoreW    = 32;
  localparam int SpW       = 5;

  typedef logic [TidW-1:0] tid_t;
  typedef logic [ClsW-1:0] cls_t;
  typedef logic [KeyW-1:0] key_t;

  typedef enum logic [2:0] {
    MODE_SCHED  = 3'd0,
    MODE_SLEEP  = 3'd1,
    MODE_AWAKE  = 3'd2,
    MODE_EXIT   = 3'd3,
    MODE_CREATE = 3'd4,
    MODE_EXEC   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_RUNNING  = 2'd0,
    ST_SLEEPING = 2'd1,
    ST_EXITING  = 2'd2,
    ST_UNUSED   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_RDW, S_SCAN, S_SCLS, S_SCLS2, S_SDONE,
    S_AWK, S_AWK2, S_CRT, S_CRT2, S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0] mode;
    tid_t       task_id;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic switched;
    tid_t current_task;
    cls_t task_class;
    logic error;
  } rsp_t;

  // Class from a clamped score.
  function automatic cls_t class_of(logic [ScoreW-1:0] sl, logic [SpW-1:0] sp);
    logic signed [12:0] s;
    logic signed [12:0] d;
    logic [3:0] c;
    s = (sl > 32'd1000) ? 13'sd1000 : signed'({3'b000, sl[9:0]});
    d = signed'({{8{sp[SpW-1]}}, sp}) * 13'sd10;
    s = s + d;
    if (s < 0) s = 13'sd0;
    if (s > 13'sd1000) s = 13'sd1000;
    if (s >= 13'sd900) c = 4'd0;
    else if (s >= 13'sd800) c = 4'd1;
    else if (s >= 13'sd700) c = 4'd2;
    else if (s >= 13'sd600) c = 4'd3;
    else if (s >= 13'sd500) c = 4'd4;
    else if (s >= 13'sd400) c = 4'd5;
    else if (s >= 13'sd300) c = 4'd6;
    else if (s >= 13'sd200) c = 4'd7;
    else if (s >= 13'sd100) c = 4'd8;
    else c = 4'd9;
    if (c > cls_t'(NumQueues - 1)) c = cls_t'(NumQueues - 1);
    return c;
  endfunction
endpackage

// ===== hdl/mqs_req_if.sv =====
interface mqs_req_if;
  logic          valid;
  logic          ready;
  mqs_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/mqs_rsp_if.sv =====
interface mqs_rsp_if;
  logic          valid;
  logic          ready;
  mqs_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/mqs_ram.sv =====
module mqs_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/multilevel_queue_task_scheduler.sv =====
// Multilevel queue task scheduler: one request in, one response out. A schedule
// request scans the whole task table, one entry per cycle from the attribute RAM,
// while a single compare unit tracks the best candidate. A new request is taken
// only once the last one's response has been loaded into the output register.
// Sleep, exit, exec and unknown modes go from the RAM read straight to the
// response step; awake and create pass through their own update states first. A
// registered response output parts the two sides: a response still waiting for
// its transfer stalls only the final step of the following request. Queued and
// status bits clear at reset, only the idle task is marked valid, and the idle
// task's RAM entry is written while reset is held; other entries are undefined
// until a create writes them.
module multilevel_queue_task_scheduler (
  input logic clk,
  input logic rst,
  mqs_req_if.sink   req,
  mqs_rsp_if.source rsp
);
  localparam int AttrW = 4 + mqs_pkg::ClsW + mqs_pkg::ScoreW + mqs_pkg::SpW
                         + mqs_pkg::KeyW;
  localparam mqs_pkg::cls_t IdleCls = (mqs_pkg::NumQueues - 1 < 9) ?
                                      mqs_pkg::cls_t'(mqs_pkg::NumQueues - 1) :
                                      mqs_pkg::cls_t'(9);
  // attribute word: {queue_member, priority_class, sleep_score, static_prio, order_key}
  typedef struct packed {
    logic [3:0]                 qm;
    mqs_pkg::cls_t              pc;
    logic [mqs_pkg::ScoreW-1:0] sl;
    logic [mqs_pkg::SpW-1:0]    sp;
    mqs_pkg::key_t              key;
  } attr_t;

  mqs_pkg::state_t state, state_next;
  logic [mqs_pkg::MaxTasks-1:0] valid_b, queued_b;
  logic [1:0] status [mqs_pkg::MaxTasks];
  mqs_pkg::tid_t running, cur;
  mqs_pkg::key_t head, tail;
  mqs_pkg::req_t rq;
  mqs_pkg::rsp_t res;
  mqs_pkg::rsp_t out;
  logic out_valid;
  logic load_out;

  logic [mqs_pkg::TidW:0] cnt;
  logic found;
  mqs_pkg::tid_t best;
  logic [3:0] bq;
  mqs_pkg::key_t bkey;
  mqs_pkg::tid_t scan_t;
  logic scan_live;

  logic ram_we;
  mqs_pkg::tid_t ram_waddr, ram_raddr;
  attr_t ram_wdata, rd;
  attr_t a_cur;

  mqs_ram #(.Width(AttrW), .Depth(mqs_pkg::MaxTasks)) u_attr (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(rd)
  );

  assign req.ready   = (state == mqs_pkg::S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.payload = out;
  assign load_out    = (state == mqs_pkg::S_OUT) && (!out_valid || rsp.ready);

  always_comb begin
    unique case (state)
      mqs_pkg::S_SCAN: ram_raddr = cnt[mqs_pkg::TidW-1:0];
      mqs_pkg::S_AWK:  ram_raddr = rq.task_id;
      default:         ram_raddr = running;
    endcase
  end

  // Scan candidate: scan_t and rd belong to the address issued in the previous cycle.
  assign scan_live = valid_b[scan_t] && queued_b[scan_t] && (scan_t != cur)
                     && (scan_t != mqs_pkg::tid_t'(mqs_pkg::IdleTask))
                     && (rd.qm < 4'(mqs_pkg::NumQueues));

  always_comb begin
    state_next = state;
    unique case (state)
      mqs_pkg::S_IDLE: if (req.valid && req.ready) state_next = mqs_pkg::S_RD;
      mqs_pkg::S_RD: state_next = mqs_pkg::S_RDW;
      mqs_pkg::S_RDW: begin
        priority case (mqs_pkg::mode_t'(rq.mode))
          mqs_pkg::MODE_SCHED:  state_next = mqs_pkg::S_SCAN;
          mqs_pkg::MODE_AWAKE:  state_next = mqs_pkg::S_AWK;
          mqs_pkg::MODE_CREATE: state_next = mqs_pkg::S_CRT;
          default:              state_next = mqs_pkg::S_OUT;
        endcase
      end
      mqs_pkg::S_SCAN: if (cnt == (mqs_pkg::TidW+1)'(mqs_pkg::MaxTasks))
                         state_next = mqs_pkg::S_SCLS;
      mqs_pkg::S_SCLS:  state_next = mqs_pkg::S_SCLS2;
      mqs_pkg::S_SCLS2: state_next = mqs_pkg::S_SDONE;
      mqs_pkg::S_SDONE: state_next = mqs_pkg::S_OUT;
      mqs_pkg::S_AWK:   state_next = mqs_pkg::S_AWK2;
      mqs_pkg::S_AWK2:  state_next = mqs_pkg::S_OUT;
      mqs_pkg::S_CRT:   state_next = mqs_pkg::S_CRT2;
      mqs_pkg::S_CRT2:  state_next = mqs_pkg::S_OUT;
      mqs_pkg::S_OUT:   if (load_out) state_next = mqs_pkg::S_IDLE;
      default:          state_next = mqs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mqs_pkg::S_IDLE;
    else state <= state_next;
  end

  // RAM write port; the idle task entry is seeded while reset is held
  always_comb begin
    logic [31:0] d;
    attr_t w;
    d = rq.now - rd.sl;
    w = rd;
    ram_we = 1'b0;
    ram_waddr = running;
    ram_wdata = rd;
    if (rst) begin
      w = '0;
      w.pc = IdleCls;
      ram_we = 1'b1;
      ram_waddr = mqs_pkg::tid_t'(mqs_pkg::IdleTask);
      ram_wdata = w;
    end else begin
      unique case (state)
        mqs_pkg::S_RDW: begin
          w = rd;
          if (rq.mode == mqs_pkg::MODE_SLEEP) begin
            w.sl = rq.now; ram_we = 1'b1;
          end else if (rq.mode == mqs_pkg::MODE_EXEC) begin
            w.sl = '0; w.sp = '0; ram_we = 1'b1;
          end
          ram_wdata = w;
        end
        mqs_pkg::S_SCLS: begin
          w = a_cur;
          w.pc = mqs_pkg::class_of(a_cur.sl, a_cur.sp);
          if (found && status[cur] == mqs_pkg::ST_RUNNING) begin
            w.qm = w.pc; w.key = tail;
          end
          ram_we = (status[cur] == mqs_pkg::ST_RUNNING);
          ram_waddr = cur;
          ram_wdata = w;
        end
        mqs_pkg::S_AWK2: begin
          w = rd;
          w.sl = (d >= 32'd1000) ? 32'd1000 : d;
          w.pc = mqs_pkg::class_of(w.sl, w.sp);
          if (rq.task_id != running && status[rq.task_id] == mqs_pkg::ST_SLEEPING) begin
            w.qm = w.pc; w.key = head;
          end
          ram_we = valid_b[rq.task_id];
          ram_waddr = rq.task_id;
          ram_wdata = w;
        end
        mqs_pkg::S_CRT: begin
          w = a_cur;
          w.qm = a_cur.pc; w.key = head;
          ram_we = !valid_b[rq.task_id];
          ram_waddr = rq.task_id;
          ram_wdata = w;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b   <= mqs_pkg::MaxTasks'(1) << mqs_pkg::IdleTask;
      queued_b  <= '0;
      for (int i = 0; i < mqs_pkg::MaxTasks; i++) status[i] <= mqs_pkg::ST_RUNNING;
      running   <= mqs_pkg::tid_t'(mqs_pkg::IdleTask);
      head      <= '0;
      tail      <= mqs_pkg::key_t'(1);
      out_valid <= 1'b0;
    end else begin
      out_valid <= load_out || (out_valid && !rsp.ready);
      unique case (state)
        mqs_pkg::S_IDLE: if (req.valid && req.ready) begin
          rq  <= req.payload;
          cur <= running;
          res <= '0;
        end
        mqs_pkg::S_RD: ;
        mqs_pkg::S_RDW: begin
          a_cur <= rd;
          cnt   <= '0;
          found <= 1'b0;
          res.task_class <= rd.pc;
          if (rq.mode == mqs_pkg::MODE_SLEEP) status[running] <= mqs_pkg::ST_SLEEPING;
          if (rq.mode == mqs_pkg::MODE_EXEC)  status[running] <= mqs_pkg::ST_RUNNING;
          if (rq.mode == mqs_pkg::MODE_EXIT &&
              running != mqs_pkg::tid_t'(mqs_pkg::IdleTask))
            status[running] <= mqs_pkg::ST_EXITING;
        end
        mqs_pkg::S_SCAN: begin
          cnt <= cnt + 1'b1;
          scan_t <= cnt[mqs_pkg::TidW-1:0];
          if (cnt != '0 && scan_live &&
              (!found || rd.qm < bq ||
               (rd.qm == bq && $signed(rd.key) < $signed(bkey)))) begin
            found <= 1'b1; best <= scan_t; bq <= rd.qm; bkey <= rd.key;
          end
        end
        mqs_pkg::S_SCLS: begin
          if (status[cur] == mqs_pkg::ST_RUNNING)
            res.task_class <= mqs_pkg::class_of(a_cur.sl, a_cur.sp);
          if (found) begin
            running <= best;
            unique case (mqs_pkg::status_t'(status[cur]))
              mqs_pkg::ST_RUNNING: begin queued_b[cur] <= 1'b1; tail <= tail + 1'b1; end
              mqs_pkg::ST_SLEEPING: queued_b[cur] <= 1'b0;
              mqs_pkg::ST_EXITING: begin queued_b[cur] <= 1'b0; valid_b[cur] <= 1'b0; end
              default: ;
            endcase
          end else if (status[cur] != mqs_pkg::ST_RUNNING) begin
            running <= mqs_pkg::tid_t'(mqs_pkg::IdleTask);
            if (status[cur] != mqs_pkg::ST_UNUSED) queued_b[cur] <= 1'b0;
            if (status[cur] == mqs_pkg::ST_EXITING) valid_b[cur] <= 1'b0;
          end
        end
        mqs_pkg::S_SCLS2: ;
        mqs_pkg::S_SDONE: res.switched <= (running != cur);
        mqs_pkg::S_AWK: ;
        mqs_pkg::S_AWK2: begin
          if (!valid_b[rq.task_id]) begin
            res.error <= 1'b1; res.task_class <= '0;
          end else begin
            res.task_class <= ram_wdata.pc;
            if (rq.task_id != running && status[rq.task_id] == mqs_pkg::ST_SLEEPING) begin
              queued_b[rq.task_id] <= 1'b1; head <= head - 1'b1;
            end
            status[rq.task_id] <= mqs_pkg::ST_RUNNING;
          end
        end
        mqs_pkg::S_CRT: begin
          if (valid_b[rq.task_id]) begin
            res.error <= 1'b1; res.task_class <= '0;
          end else begin
            valid_b[rq.task_id] <= 1'b1;
            queued_b[rq.task_id] <= 1'b1;
            status[rq.task_id] <= status[running];
            head <= head - 1'b1;
            res.task_class <= a_cur.pc;
          end
        end
        mqs_pkg::S_CRT2: ;
        mqs_pkg::S_OUT: begin
          if (load_out)
            out <= '{switched: res.switched, current_task: running,
                     task_class: res.task_class, error: res.error};
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== hdl/mqs_checker.sv =====
`include "multilevel_queue_task_scheduler_assert.svh"
module mqs_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_err,
  input logic rsp_sw,
  input logic [3:0] rsp_cls
);
  `MQS_ASSERT_NXT(a_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
  `MQS_ASSERT_NXT(a_one, clk, rst, req_valid && req_ready, !req_ready, "took two items")
  `MQS_ASSERT_IMP(a_errcls, clk, rst, rsp_valid && rsp_err, rsp_cls == 4'd0, "error class")
  `MQS_ASSERT_IMP(a_errsw, clk, rst, rsp_valid && rsp_err, !rsp_sw, "error with switch")
endmodule

bind multilevel_queue_task_scheduler mqs_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_err(rsp.payload.error),
  .rsp_sw(rsp.payload.switched), .rsp_cls(rsp.payload.task_class)
);
